// File: hdl/fuv_pkg.sv
// shared types, constants and the byte classifier for the framed utf-8 validator
// no dependencies; imported by every module of the block
package fuv_pkg;

  // payload length limits
  localparam logic [31:0] MAX_FRAME = 32'd65536;
  localparam logic [16:0] LEN_SAT   = 17'h10000;
  localparam logic [16:0] MAX_LEN_RESET = 17'h10000;

  // token queue between front and back
  localparam int unsigned TOK_DEPTH = 4;
  localparam int unsigned TOK_AW    = $clog2(TOK_DEPTH);
  localparam int unsigned TOK_CW    = $clog2(TOK_DEPTH + 1);

  // result queue depth inside the back end
  localparam int unsigned RES_DEPTH = 2;
  localparam int unsigned RES_AW    = $clog2(RES_DEPTH);
  localparam int unsigned RES_CW    = $clog2(RES_DEPTH + 1);

  // utf-8 range limits
  localparam logic [20:0] CP_MAX    = 21'h10ffff;
  localparam logic [20:0] SURR_LO   = 21'h00d800;
  localparam logic [20:0] SURR_HI   = 21'h00dfff;
  localparam logic [20:0] MIN_TWO   = 21'h000080;
  localparam logic [20:0] MIN_THREE = 21'h000800;
  localparam logic [20:0] MIN_FOUR  = 21'h010000;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_BAD_UTF8   = 2'd2
  } status_e;

  // meaning of a byte at the start of a sequence
  typedef enum logic [2:0] {
    BC_NUL   = 3'd0,
    BC_ASCII = 3'd1,
    BC_LEAD2 = 3'd2,
    BC_LEAD3 = 3'd3,
    BC_LEAD4 = 3'd4,
    BC_BAD   = 3'd5
  } bcls_e;

  // one transaction from the front end to the back end
  typedef struct packed {
    logic        bad_len;
    logic        first;
    logic        last;
    logic [7:0]  data;
    bcls_e       cls;
    logic        is_cont;
    logic [16:0] len;
  } tok_t;

  // one verdict waiting at the result side
  typedef struct packed {
    status_e     status;
    logic [16:0] len;
  } res_t;

  function automatic bcls_e classify_byte(input logic [7:0] b);
    bcls_e c;
    c = BC_BAD;
    if (b == 8'h00) begin
      c = BC_NUL;
    end else if (b < 8'h80) begin
      c = BC_ASCII;
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      c = BC_LEAD2;
    end else if (b >= 8'he0 && b <= 8'hef) begin
      c = BC_LEAD3;
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      c = BC_LEAD4;
    end
    return c;
  endfunction

endpackage

// File: hdl/fuv_front.sv
// front end: frame header parsing, length check, payload counting, byte classes
// depends on fuv_pkg; feeds the token queue
module fuv_front import fuv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_valid_i,
  input  logic [16:0] cfg_data_i,
  input  logic        tok_full_i,
  output logic        tok_wr_o,
  output tok_t        tok_o
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_HALTED  = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] len_q, len_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] max_q;
  logic        accept;
  logic [31:0] len_shift;
  logic        len_bad;
  logic [16:0] len_sat;

  assign accept    = push_i && !tok_full_i;
  assign len_shift = {len_q[23:0], data_byte_i};
  assign len_bad   = (len_shift == 32'd0) || (len_shift > {15'd0, max_q}) ||
                     (len_shift > MAX_FRAME);
  assign len_sat   = (len_shift > {15'd0, LEN_SAT}) ? LEN_SAT : len_shift[16:0];

  // length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // frame sequencing and token build
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    len_d     = len_q;
    rem_d     = rem_q;
    tok_wr_o  = 1'b0;
    tok_o.bad_len = 1'b0;
    tok_o.first   = (rem_q == len_q[16:0]);
    tok_o.last    = (rem_q == 17'd1);
    tok_o.data    = data_byte_i;
    tok_o.cls     = classify_byte(data_byte_i);
    tok_o.is_cont = (data_byte_i[7:6] == 2'b10);
    tok_o.len     = len_q[16:0];
    if (accept) begin
      if (action_i) begin
        phase_d   = PH_HEADER;
        hdr_cnt_d = 2'd0;
        len_d     = 32'd0;
        rem_d     = 17'd0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            len_d     = len_shift;
            hdr_cnt_d = hdr_cnt_q + 2'd1;
            if (hdr_cnt_q == 2'd3) begin
              if (len_bad) begin
                tok_wr_o      = 1'b1;
                tok_o.bad_len = 1'b1;
                tok_o.len     = len_sat;
                phase_d       = PH_HALTED;
              end else begin
                rem_d   = len_shift[16:0];
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            tok_wr_o = 1'b1;
            rem_d    = rem_q - 17'd1;
            if (rem_q == 17'd1) begin
              phase_d = PH_HEADER;
              len_d   = 32'd0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= 2'd0;
      len_q     <= 32'd0;
      rem_q     <= 17'd0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
    end
  end

  // payload phase always has bytes left
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != 17'd0 && rem_q <= len_q[16:0])
    else $error("payload phase with bad remaining count");

  // a payload frame never exceeds the saturation limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> len_q <= MAX_FRAME)
    else $error("payload length above limit");

endmodule

// File: hdl/fuv_tok_fifo.sv
// token queue between front end and back end
// depends on fuv_pkg
module fuv_tok_fifo import fuv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  tok_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output tok_t rd_data_o
);

  tok_t               mem_q [TOK_DEPTH];
  logic [TOK_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [TOK_CW-1:0]  cnt_q;
  logic               do_wr, do_rd;

  assign full_o    = (cnt_q == TOK_CW'(TOK_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + TOK_AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + TOK_AW'(1);
      end
      cnt_q <= cnt_q + TOK_CW'(do_wr) - TOK_CW'(do_rd);
    end
  end

endmodule

// File: hdl/fuv_back.sv
// back end: utf-8 sequence checker and result queue
// depends on fuv_pkg; consumes tokens from the token queue
module fuv_back import fuv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tok_valid_i,
  input  tok_t        tok_i,
  output logic        tok_rd_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [1:0]  status_o,
  output logic [16:0] frame_length_o
);

  logic [1:0]  pend_q, size_q, pend_e, size_e, pend_n, size_n;
  logic [20:0] cp_q, cp_e, cp_n, cp_c;
  logic        fail_q, fail_e, fail_n;
  logic [20:0] cp_min;
  logic        take, emit;
  res_t        res_d;

  res_t              res_q [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CW-1:0] cnt_q;
  logic              do_pop;

  assign take     = tok_valid_i && (cnt_q != RES_CW'(RES_DEPTH));
  assign tok_rd_o = take;
  assign emit     = take && (tok_i.bad_len || tok_i.last);

  // sequence state as seen by this byte, cleared at frame start
  always_comb begin
    if (tok_i.first) begin
      pend_e = 2'd0;
      size_e = 2'd0;
      cp_e   = 21'd0;
      fail_e = 1'b0;
    end else begin
      pend_e = pend_q;
      size_e = size_q;
      cp_e   = cp_q;
      fail_e = fail_q;
    end
  end

  // one byte of utf-8 checking
  always_comb begin
    pend_n = pend_e;
    size_n = size_e;
    cp_n   = cp_e;
    fail_n = fail_e;
    cp_c   = {cp_e[14:0], tok_i.data[5:0]};
    case (size_e)
      2'd1:    cp_min = MIN_TWO;
      2'd2:    cp_min = MIN_THREE;
      default: cp_min = MIN_FOUR;
    endcase
    if (!fail_e) begin
      if (pend_e == 2'd0) begin
        case (tok_i.cls)
          BC_NUL:   fail_n = 1'b1;
          BC_ASCII: ;
          BC_LEAD2: begin
            pend_n = 2'd1;
            size_n = 2'd1;
            cp_n   = {16'd0, tok_i.data[4:0]};
          end
          BC_LEAD3: begin
            pend_n = 2'd2;
            size_n = 2'd2;
            cp_n   = {17'd0, tok_i.data[3:0]};
          end
          BC_LEAD4: begin
            pend_n = 2'd3;
            size_n = 2'd3;
            cp_n   = {18'd0, tok_i.data[2:0]};
          end
          default:  fail_n = 1'b1;
        endcase
      end else if (!tok_i.is_cont) begin
        fail_n = 1'b1;
      end else begin
        pend_n = pend_e - 2'd1;
        cp_n   = cp_c;
        if (pend_e == 2'd1) begin
          if (cp_c < cp_min || cp_c > CP_MAX || (cp_c >= SURR_LO && cp_c <= SURR_HI)) begin
            fail_n = 1'b1;
          end
          cp_n   = 21'd0;
          size_n = 2'd0;
        end
      end
    end
  end

  // verdict for the result queue
  always_comb begin
    res_d.len = tok_i.len;
    if (tok_i.bad_len) begin
      res_d.status = ST_BAD_LENGTH;
    end else if (fail_n || pend_n != 2'd0) begin
      res_d.status = ST_BAD_UTF8;
    end else begin
      res_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      size_q <= 2'd0;
      cp_q   <= 21'd0;
      fail_q <= 1'b0;
    end else if (take && !tok_i.bad_len) begin
      pend_q <= pend_n;
      size_q <= size_n;
      cp_q   <= cp_n;
      fail_q <= fail_n;
    end
  end

  // result queue
  assign empty_o        = (cnt_q == '0);
  assign do_pop         = pop_i && !empty_o;
  assign status_o       = res_q[rd_ptr_q].status;
  assign frame_length_o = res_q[rd_ptr_q].len;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (emit) begin
        wr_ptr_q <= wr_ptr_q + RES_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + RES_AW'(1);
      end
      cnt_q <= cnt_q + RES_CW'(emit) - RES_CW'(do_pop);
    end
  end

  // result queue never overfills
  a_res_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CW'(RES_DEPTH))
    else $error("result queue overflow");

  // open sequence never has more bytes pending than its size
  a_pend_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd0 |-> size_q >= pend_q)
    else $error("pending count exceeds sequence size");

  // no open sequence means the accumulator is clear
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> cp_q == 21'd0 && size_q == 2'd0)
    else $error("stale code point with no open sequence");

  // a verdict lands in the queue the cycle after it is formed
  a_emit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !do_pop |=> cnt_q == $past(cnt_q) + RES_CW'(1))
    else $error("verdict lost on the way to the result queue");

endmodule

// File: hdl/framed_utf8_validator.sv
// top level of the framed utf-8 validator
// depends on fuv_pkg, fuv_front, fuv_tok_fifo, fuv_back
//
// The block takes one stream byte per clock (push while full is low) and gives one
// verdict per frame: a 4-byte big-endian length, then the payload checked as strict
// UTF-8. The front end parses headers and counts payload bytes; it hands each
// payload byte or bad-length verdict through a 4-entry token queue to the back end,
// which runs the UTF-8 checker and keeps a 2-entry result queue. Throughput is one
// byte per cycle while full is low; the last payload byte (or the last header byte
// for a bad length) passes through the token queue, and the frame's verdict is then
// registered into the result queue, from which it shows on the result side. full rises
// only when the result side is stalled and both queues have filled. The length limit
// written on the configuration port is always accepted, used at the next length check.
module framed_utf8_validator import fuv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [16:0] frame_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  logic tok_wr, tok_full, tok_valid, tok_rd;
  tok_t tok_wr_data, tok_rd_data;

  assign cfg_ready_o = 1'b1;
  assign full        = tok_full;

  // header parsing and byte classification
  fuv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .tok_full_i  (tok_full),
    .tok_wr_o    (tok_wr),
    .tok_o       (tok_wr_data)
  );

  // decoupling queue
  fuv_tok_fifo u_tok_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tok_wr),
    .wr_data_i (tok_wr_data),
    .full_o    (tok_full),
    .rd_i      (tok_rd),
    .valid_o   (tok_valid),
    .rd_data_o (tok_rd_data)
  );

  // utf-8 checking and result queue
  fuv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_valid_i    (tok_valid),
    .tok_i          (tok_rd_data),
    .tok_rd_o       (tok_rd),
    .empty_o        (empty),
    .pop_i          (pop),
    .status_o       (status_o),
    .frame_length_o (frame_length_o)
  );

endmodule
